// File: hdl/u16dec_pkg.sv
// ----------------------------------------------------------------------------
// u16dec_pkg
// Shared types, constants and the decimal digit step for the 16-bit
// binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package u16dec_pkg;

	localparam int unsigned DIGITS_MAX = 5;
	localparam int unsigned IDX_W      = $clog2(DIGITS_MAX);

	localparam logic [5:0]  ASCII_ZERO = 6'h30;

	localparam logic [15:0] W_10000 = 16'd10000;
	localparam logic [15:0] W_1000  = 16'd1000;
	localparam logic [15:0] W_100   = 16'd100;
	localparam logic [15:0] W_10    = 16'd10;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIGITS_MAX - 1);

	typedef logic [3:0] digit_t;

	typedef struct packed {
		digit_t      digit;
		logic [15:0] rest;
	} dstep_t;

	// One decimal place: parallel compares against 1..9 times the weight.
	// The caller guarantees rest < 10 * weight (or weight is the top place).
	function automatic dstep_t dec_step(input logic [15:0] rest, input logic [15:0] weight);
		dstep_t      r;
		logic [19:0] prod;
		r.digit = '0;
		r.rest  = rest;
		for (int k = 1; k <= 9; k++) begin
			prod = 20'(k) * {4'b0000, weight};
			if ({4'b0000, rest} >= prod) begin
				r.digit = 4'(k);
				r.rest  = rest - prod[15:0];
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hdl/u16_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// u16_to_decimal_ascii_core
// Unsigned 16-bit value to decimal ASCII characters, one character per
// output request, most significant digit first.
// ----------------------------------------------------------------------------
// A value enters each cycle the front of the pipe has room. Digits are peeled
// off one decimal place per stage (ten-thousands, thousands, hundreds, then
// tens and units together), four stages deep, and the result lands in an
// output stage that sends one character per cycle while char_stall is low.
// A value has 1 to 5 characters in suppress mode, 5 in padded mode, so the
// sustained input rate is set by the character count of each value. A value
// waiting in stage 4 loads into the output stage in the same cycle the
// last character is taken, so no gap. The user writes pad_mode through the
// cfg channel (always ready) only when idle; the block does not enforce it.
`default_nettype none

module u16_to_decimal_ascii_core (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic                   cfg_data,
	// value requests
	input  wire logic                   value_valid,
	output logic                        value_stall,
	input  wire logic [15:0]            value,
	// character requests
	output logic                        char_valid,
	input  wire logic                   char_stall,
	output logic [5:0]                  ascii_char,
	output logic                        is_last,
	output logic [2:0]                  char_count
);

	import u16dec_pkg::*;

	logic pad_q;

	// pipeline
	logic        vld_s1, vld_s2, vld_s3, vld_s4;
	logic        pad_s1, pad_s2, pad_s3, pad_s4;
	logic [15:0] val_s1;
	logic [13:0] rest_s2;
	logic [9:0]  rest_s3;
	logic [6:0]  rest_s4;
	digit_t      d0_s2, d0_s3, d0_s4;
	digit_t      d1_s3, d1_s4;
	digit_t      d2_s4;

	// output stage
	logic             vld_q;
	digit_t           dig_q [DIGITS_MAX];
	logic [IDX_W-1:0] idx_q;
	logic [2:0]       cnt_q;

	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, ld_ok;

	dstep_t st2, st3, st4, st5;
	digit_t dig_n [DIGITS_MAX];
	logic [IDX_W-1:0] first_n;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q <= 1'b0;
		end else if (cfg_valid) begin
			pad_q <= cfg_data;
		end
	end

	// output stage takes a new value when empty or when its last char goes
	assign ld_ok  = !vld_q || (!char_stall && (idx_q == IDX_LAST));
	assign rdy_s4 = !vld_s4 || ld_ok;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;

	assign value_stall = !rdy_s1;

	always_comb begin
		st2 = dec_step(val_s1, W_10000);
		st3 = dec_step({2'b00, rest_s2}, W_1000);
		st4 = dec_step({6'b000000, rest_s3}, W_100);
		st5 = dec_step({9'b000000000, rest_s4}, W_10);
	end

	always_comb begin
		dig_n[0] = d0_s4;
		dig_n[1] = d1_s4;
		dig_n[2] = d2_s4;
		dig_n[3] = st5.digit;
		dig_n[4] = st5.rest[3:0];
		// units digit is always kept
		if (pad_s4 || (dig_n[0] != '0))
			first_n = IDX_W'(0);
		else if (dig_n[1] != '0)
			first_n = IDX_W'(1);
		else if (dig_n[2] != '0)
			first_n = IDX_W'(2);
		else if (dig_n[3] != '0)
			first_n = IDX_W'(3);
		else
			first_n = IDX_LAST;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_q  <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (rdy_s1) vld_s1 <= value_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (ld_ok) begin
				vld_q <= vld_s4;
				idx_q <= first_n;
			end else if (!char_stall) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			val_s1 <= value;
			pad_s1 <= pad_q;
		end
		if (rdy_s2) begin
			rest_s2 <= st2.rest[13:0];
			d0_s2   <= st2.digit;
			pad_s2  <= pad_s1;
		end
		if (rdy_s3) begin
			rest_s3 <= st3.rest[9:0];
			d0_s3   <= d0_s2;
			d1_s3   <= st3.digit;
			pad_s3  <= pad_s2;
		end
		if (rdy_s4) begin
			rest_s4 <= st4.rest[6:0];
			d0_s4   <= d0_s3;
			d1_s4   <= d1_s3;
			d2_s4   <= st4.digit;
			pad_s4  <= pad_s3;
		end
		if (ld_ok) begin
			for (int i = 0; i < DIGITS_MAX; i++)
				dig_q[i] <= dig_n[i];
			cnt_q <= 3'(DIGITS_MAX) - 3'(first_n);
		end
	end

	assign char_valid = vld_q;
	assign ascii_char = ASCII_ZERO + {2'b00, dig_q[idx_q]};
	assign is_last    = (idx_q == IDX_LAST);
	assign char_count = cnt_q;

endmodule

`default_nettype wire

// File: hdl/u16dec_chk.sv
// ----------------------------------------------------------------------------
// u16dec_chk
// Port-level checks for the decimal ASCII converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module u16dec_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        char_valid,
	input wire logic        char_stall,
	input wire logic [5:0]  ascii_char,
	input wire logic        is_last,
	input wire logic [2:0]  char_count
);

	// a value's characters go out without a gap
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !char_stall && !is_last |=> char_valid)
		else $error("gap inside a value's characters");

	// count stays the same across one value
	a_count_held: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !char_stall && !is_last |=> char_count == $past(char_count))
		else $error("char_count changed within a value");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> (ascii_char >= 6'd48) && (ascii_char <= 6'd57)
			&& (char_count >= 3'd1) && (char_count <= 3'd5))
		else $error("character or count out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && char_stall |=> char_valid && $stable(ascii_char)
			&& $stable(is_last) && $stable(char_count))
		else $error("stalled character request changed");

endmodule

bind u16_to_decimal_ascii_core u16dec_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.char_valid (char_valid),
	.char_stall (char_stall),
	.ascii_char (ascii_char),
	.is_last    (is_last),
	.char_count (char_count)
);

`default_nettype wire
